[rtl/led_display_key_scan_serial_master_macros.svh]
// Assertion macros for the LED display / key-scan serial master checker.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef LED_DISPLAY_KEY_SCAN_SERIAL_MASTER_MACROS_SVH
`define LED_DISPLAY_KEY_SCAN_SERIAL_MASTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LEDKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LEDKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ledks_pkg.sv]
// Package for the LED display / key-scan serial master: item types, frame
// sequencer states, controller command bytes and segment table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ledks_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int SEG_ENTRIES = 34;

  // Item commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  // Sequencer phase within one strobe-framed transaction
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN,
    PH_BITS,
    PH_CLOSE,
    PH_GAP
  } phase_t;

  // Transactions of a frame, in order
  typedef enum logic [1:0] {
    TX_MODE,
    TX_DISPLAY,
    TX_KEYS,
    TX_BRIGHT
  } txn_t;

  // Controller command bytes
  localparam logic [7:0] OP_WRITE_AUTO  = 8'h40;
  localparam logic [7:0] OP_ADDR_ZERO   = 8'hC0;
  localparam logic [7:0] OP_READ_KEYS   = 8'h42;
  localparam logic [7:0] OP_DISPLAY_ON  = 8'h88;
  localparam logic [7:0] OP_DISPLAY_OFF = 8'h80;
  localparam logic [7:0] OP_ZERO_BYTE   = 8'h00;

  localparam logic [5:0] CODE_BLANK = 6'd32;
  localparam logic [3:0] BRIGHT_MAX = 4'd8;
  localparam logic [3:0] BRIGHT_RESET = 4'd5;

  // Bytes per transaction (command byte included)
  localparam logic [4:0] DISPLAY_BYTES = 5'd17;
  localparam logic [4:0] KEY_BYTES     = 5'd5;
  localparam logic [4:0] SINGLE_BYTE   = 5'd1;

  localparam logic [7:0] SEG_TABLE [SEG_ENTRIES] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
    8'hBF, 8'h86, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'hA7,
    8'hFF, 8'hEF, 8'hF7, 8'hFC, 8'hB9, 8'hDE, 8'hF9, 8'hF1,
    8'h00, 8'h40
  };

  typedef struct packed {
    logic strobe;
    logic clock;
    logic data;
  } pins_t;

  localparam pins_t PINS_IDLE = '{strobe: 1'b1, clock: 1'b1, data: 1'b1};

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] digit_index;
    logic [5:0] digit_code;
    logic       dio_in;
  } item_t;

  typedef struct packed {
    logic       strobe_pin;
    logic       clock_pin;
    logic       data_out_pin;
    logic       busy_res;
    logic [5:0] key_code;
    logic       key_valid;
  } result_t;

  // Segment pattern of a digit code; codes past the table are blank
  function automatic logic [7:0] seg_of(input logic [5:0] code);
    logic [7:0] seg;
    seg = 8'h00;
    if (code < 6'(SEG_ENTRIES)) begin
      seg = SEG_TABLE[code];
    end
    return seg;
  endfunction

  // Brightness command byte; levels above the top saturate
  function automatic logic [7:0] bright_cmd(input logic [3:0] level);
    logic [3:0] lv;
    logic [7:0] op;
    lv = (level > BRIGHT_MAX) ? BRIGHT_MAX : level;
    if (lv == 4'd0) begin
      op = OP_DISPLAY_OFF;
    end else begin
      op = OP_DISPLAY_ON | {5'd0, 3'(lv - 4'd1)};
    end
    return op;
  endfunction

  function automatic logic [4:0] tx_bytes(input txn_t txn);
    logic [4:0] n;
    case (txn)
      TX_DISPLAY: n = DISPLAY_BYTES;
      TX_KEYS:    n = KEY_BYTES;
      default:    n = SINGLE_BYTE;
    endcase
    return n;
  endfunction

  function automatic txn_t next_txn(input txn_t txn);
    txn_t n;
    case (txn)
      TX_MODE:    n = TX_DISPLAY;
      TX_DISPLAY: n = TX_KEYS;
      default:    n = TX_BRIGHT;
    endcase
    return n;
  endfunction

  // Index of the highest set bit of a byte (zero when none is set)
  function automatic logic [2:0] msb_index(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/ledks_if.sv]
// Valid/ready channel interfaces for the LED display / key-scan serial master.
// Depends on nothing; payload widths follow the item and result formats.
`timescale 1ns / 1ps
`default_nettype none

interface ledks_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] digit_index;
  logic [5:0] digit_code;
  logic       dio_in;

  modport source (output valid, command, digit_index, digit_code, dio_in, input ready);
  modport sink   (input valid, command, digit_index, digit_code, dio_in, output ready);
endinterface

interface ledks_result_if;
  logic       valid;
  logic       ready;
  logic       strobe_pin;
  logic       clock_pin;
  logic       data_out_pin;
  logic       busy_res;
  logic [5:0] key_code;
  logic       key_valid;

  modport source (output valid, strobe_pin, clock_pin, data_out_pin, busy_res, key_code,
                  key_valid, input ready);
  modport sink   (input valid, strobe_pin, clock_pin, data_out_pin, busy_res, key_code,
                  key_valid, output ready);
endinterface

`default_nettype wire

[rtl/led_display_key_scan_serial_master.sv]
// LED display / key-scan serial master top level: input register, frame
// sequencer (ledks_frame_seq), result register. Depends on ledks_pkg, ledks_if.
//
// Usage:
//   item channel carries commands: tick, load digit (digit_index, digit_code),
//   start frame. Each accepted item yields exactly one result item with the
//   three pin levels, busy flag, last key code and a key_valid pulse.
//   cfg_we/cfg_wdata write the 4-bit brightness register; write it while no
//   item is in flight.
// Pipeline: an accepted item sits in the input register; the sequencer steps
//   it when the result register has room, and its result is then loaded into
//   the result register.
// Throughput: one item per clock while result.ready is high; the sequencer step
//   between the input and result registers is a single pass of short logic.
// Reset: pins all high, sequencer idle, digit codes zero, brightness 5, both
//   registers empty. A start then clocks out the frame one tick per pin phase.
// Stall: when the receiver holds ready low, the result register holds its
//   item, the input register fills, and item.ready drops until space frees up.
`timescale 1ns / 1ps
`default_nettype none

module led_display_key_scan_serial_master import ledks_pkg::*; #(
  parameter int NUM_DIGITS    = 8,
  parameter int STB_GAP_TICKS = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_wdata,
  ledks_item_if.sink      item,
  ledks_result_if.source  result
);

  logic       in_valid;
  item_t      in_item;
  logic       res_valid;
  result_t    res_item;
  result_t    seq_result;
  logic       advance;
  logic [3:0] brightness;

  // Step the sequencer when the result register has room
  assign advance    = in_valid && (!res_valid || result.ready);
  assign item.ready = !in_valid || advance;

  // Brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_RESET;
    end else if (cfg_we) begin
      brightness <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item <= '{command: item.command, digit_index: item.digit_index,
                   digit_code: item.digit_code, dio_in: item.dio_in};
    end
  end

  ledks_frame_seq #(
    .NUM_DIGITS    (NUM_DIGITS),
    .STB_GAP_TICKS (STB_GAP_TICKS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (in_item),
    .brightness (brightness),
    .result     (seq_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= seq_result;
    end
  end

  assign result.valid        = res_valid;
  assign result.strobe_pin   = res_item.strobe_pin;
  assign result.clock_pin    = res_item.clock_pin;
  assign result.data_out_pin = res_item.data_out_pin;
  assign result.busy_res     = res_item.busy_res;
  assign result.key_code     = res_item.key_code;
  assign result.key_valid    = res_item.key_valid;

endmodule

`default_nettype wire

[rtl/ledks_frame_seq.sv]
// Frame sequencer: digit store, grid snapshot, pin waveform and key decode.
// Depends on ledks_pkg. State advances on each item the top level steps in.
`timescale 1ns / 1ps
`default_nettype none

module ledks_frame_seq import ledks_pkg::*; #(
  parameter int NUM_DIGITS    = 8,
  parameter int STB_GAP_TICKS = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [3:0] brightness,
  output result_t    result
);

  phase_t      phase, phase_next;
  txn_t        txn, txn_next;
  logic [4:0]  byte_cnt, byte_cnt_next;
  logic [3:0]  bit_ph, bit_ph_next;
  logic [7:0]  gap_cnt, gap_cnt_next;
  logic [7:0]  shift, shift_next;
  logic [5:0]  key_acc, key_acc_next;
  logic [5:0]  key_reg, key_reg_next;
  pins_t       pins, pins_next;
  logic        key_pulse;

  logic [5:0]  digit_store [MAX_DIGITS];
  logic [7:0]  grid [MAX_DIGITS];
  logic [7:0]  snap [MAX_DIGITS];
  logic [7:0]  seg [MAX_DIGITS];

  logic        is_tick;
  logic        do_start;
  logic        rd;
  logic [4:0]  byte_inc;
  logic [4:0]  byte_m1;
  logic [7:0]  gap_inc;
  logic [7:0]  wr_byte;
  logic [7:0]  sb;

  assign is_tick  = (item.command == CMD_TICK);
  assign do_start = (item.command == CMD_START) && (phase == PH_IDLE);
  assign rd       = (txn == TX_KEYS) && (byte_cnt != 5'd0);
  assign byte_inc = byte_cnt + 5'd1;
  assign byte_m1  = byte_cnt - 5'd1;
  assign gap_inc  = gap_cnt + 8'd1;

  // Digit store: one register per digit, digits past NUM_DIGITS read blank
  for (genvar d = 0; d < MAX_DIGITS; d++) begin : g_digit
    if (d < NUM_DIGITS) begin : g_used
      always_ff @(posedge clk) begin
        if (rst) begin
          digit_store[d] <= 6'd0;
        end else if (step && item.command == CMD_LOAD && item.digit_index == 3'(d)) begin
          digit_store[d] <= item.digit_code;
        end
      end
    end else begin : g_unused
      assign digit_store[d] = CODE_BLANK;
    end
    assign seg[d] = seg_of(digit_store[d]);
  end

  // Transpose segments: grid byte g, bit 7-d, is segment g of digit d
  always_comb begin
    for (int g = 0; g < MAX_DIGITS; g++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        snap[g][MAX_DIGITS - 1 - d] = seg[d][g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && do_start) begin
      grid <= snap;
    end
  end

  // Byte to shift out for the current transaction and byte count
  always_comb begin
    case (txn)
      TX_MODE: wr_byte = OP_WRITE_AUTO;
      TX_DISPLAY: begin
        if (byte_cnt == 5'd0) begin
          wr_byte = OP_ADDR_ZERO;
        end else if (byte_cnt[0]) begin
          wr_byte = grid[byte_m1[3:1]];
        end else begin
          wr_byte = OP_ZERO_BYTE;
        end
      end
      TX_KEYS: wr_byte = OP_READ_KEYS;
      default: wr_byte = bright_cmd(brightness);
    endcase
  end

  // Next phase and transaction
  always_comb begin
    phase_next = phase;
    txn_next   = txn;
    case (phase)
      PH_IDLE: begin
        if (do_start) begin
          phase_next = PH_OPEN;
          txn_next   = TX_MODE;
        end
      end
      PH_OPEN: begin
        if (is_tick) begin
          phase_next = PH_BITS;
        end
      end
      PH_BITS: begin
        if (is_tick && bit_ph == 4'hF && byte_inc >= tx_bytes(txn)) begin
          phase_next = PH_CLOSE;
        end
      end
      PH_CLOSE: begin
        if (is_tick) begin
          phase_next = (txn == TX_BRIGHT) ? PH_IDLE : PH_GAP;
        end
      end
      PH_GAP: begin
        if (is_tick && gap_inc >= 8'(STB_GAP_TICKS)) begin
          phase_next = PH_OPEN;
          txn_next   = next_txn(txn);
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Pin waveform, shifter, counters and key decode for one tick
  always_comb begin
    pins_next     = pins;
    byte_cnt_next = byte_cnt;
    bit_ph_next   = bit_ph;
    gap_cnt_next  = gap_cnt;
    shift_next    = shift;
    key_acc_next  = key_acc;
    key_reg_next  = key_reg;
    key_pulse     = 1'b0;
    sb            = (bit_ph == 4'd0) ? wr_byte : shift;
    if (is_tick) begin
      case (phase)
        PH_OPEN: begin
          pins_next     = '{strobe: 1'b0, clock: 1'b1, data: 1'b1};
          byte_cnt_next = 5'd0;
          bit_ph_next   = 4'd0;
          if (txn == TX_KEYS) begin
            key_acc_next = 6'd0;
          end
        end
        PH_BITS: begin
          if (!bit_ph[0]) begin
            // falling clock edge: drive data, release it for read bits
            if (rd) begin
              pins_next = '{strobe: 1'b0, clock: 1'b0, data: 1'b1};
            end else begin
              shift_next = sb;
              pins_next  = '{strobe: 1'b0, clock: 1'b0, data: sb[0]};
            end
          end else begin
            // rising clock edge: sample on reads, shift on writes
            pins_next.clock = 1'b1;
            shift_next = rd ? {shift[6:0], item.dio_in} : {1'b0, shift[7:1]};
          end
          if (bit_ph == 4'hF) begin
            // later key bytes hold higher bits, so a nonzero byte overrides
            if (rd && shift_next != 8'd0) begin
              key_acc_next = {1'b0, 2'(byte_m1), msb_index(shift_next)} + 6'd1;
            end
            byte_cnt_next = byte_inc;
            bit_ph_next   = 4'd0;
          end else begin
            bit_ph_next = bit_ph + 4'd1;
          end
        end
        PH_CLOSE: begin
          pins_next    = PINS_IDLE;
          gap_cnt_next = 8'd0;
          if (txn == TX_KEYS) begin
            key_reg_next = key_acc;
            key_pulse    = 1'b1;
          end
        end
        PH_GAP: begin
          pins_next    = PINS_IDLE;
          gap_cnt_next = gap_inc;
        end
        default: begin
          pins_next = pins;
        end
      endcase
    end
  end

  // Result reflects the state after this item
  always_comb begin
    result.strobe_pin   = pins_next.strobe;
    result.clock_pin    = pins_next.clock;
    result.data_out_pin = pins_next.data;
    result.busy_res     = (phase_next != PH_IDLE);
    result.key_code     = key_reg_next;
    result.key_valid    = key_pulse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      txn      <= TX_MODE;
      byte_cnt <= 5'd0;
      bit_ph   <= 4'd0;
      gap_cnt  <= 8'd0;
      shift    <= 8'd0;
      key_acc  <= 6'd0;
      key_reg  <= 6'd0;
      pins     <= PINS_IDLE;
    end else if (step) begin
      phase    <= phase_next;
      txn      <= txn_next;
      byte_cnt <= byte_cnt_next;
      bit_ph   <= bit_ph_next;
      gap_cnt  <= gap_cnt_next;
      shift    <= shift_next;
      key_acc  <= key_acc_next;
      key_reg  <= key_reg_next;
      pins     <= pins_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ledks_checker.sv]
// Port-level checker for the LED display / key-scan serial master, bound to
// the top level. Depends on led_display_key_scan_serial_master_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "led_display_key_scan_serial_master_macros.svh"

module ledks_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       strobe_pin,
  input wire logic       clock_pin,
  input wire logic       data_out_pin,
  input wire logic       busy_res,
  input wire logic [5:0] key_code,
  input wire logic       key_valid
);

  // A stalled result item holds
  `LEDKS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(key_code) && $stable(busy_res) && $stable(strobe_pin) && $stable(clock_pin), "result item changed while stalled")

  // Idle lines all sit high
  `LEDKS_ASSERT_NOW(a_idle_lines, res_valid && !busy_res, strobe_pin && clock_pin && data_out_pin, "lines not released while idle")

  // A key decode happens on a close tick
  `LEDKS_ASSERT_NOW(a_key_on_close, res_valid && key_valid, strobe_pin && clock_pin && data_out_pin, "key decoded outside a close tick")

  // Serial clock only drops inside a strobe frame
  `LEDKS_ASSERT_NOW(a_clk_in_frame, res_valid && !clock_pin, !strobe_pin && busy_res, "clock low outside a transaction")

  // Key code stays within range
  `LEDKS_ASSERT_NOW(a_key_range, res_valid, key_code <= 6'd32, "key code out of range")

endmodule

bind led_display_key_scan_serial_master ledks_checker u_ledks_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .strobe_pin   (result.strobe_pin),
  .clock_pin    (result.clock_pin),
  .data_out_pin (result.data_out_pin),
  .busy_res     (result.busy_res),
  .key_code     (result.key_code),
  .key_valid    (result.key_valid)
);

`default_nettype wire

[test/tb_top.sv]
// Testbench for the LED display / key-scan serial master: drives command items,
// predicts every pin/key result in a cycle-free model and checks each one in order.
// Depends on ledks_pkg, ledks_if and the led_display_key_scan_serial_master RTL.
`timescale 1ns / 1ps

module tb_top;
  import ledks_pkg::*;

  localparam int LED_DIGITS      = 8;
  localparam int STB_GAP         = 3;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int SETTLE          = 6;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int REPORT_LIMIT    = 10;
  localparam int SEG_CODES       = 34;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Controller command bytes
  localparam logic [7:0] BYTE_MODE = 8'h40;
  localparam logic [7:0] BYTE_ADDR = 8'hC0;
  localparam logic [7:0] BYTE_KEYS = 8'h42;
  localparam logic [7:0] BYTE_LIT  = 8'h88;
  localparam logic [7:0] BYTE_DARK = 8'h80;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic [3:0] LEVEL_AT_RESET = 4'd5;
  localparam logic [3:0] LEVEL_TOP      = 4'd8;

  // Segment patterns: hex digits, hex digits with point, blank, minus
  localparam logic [7:0] DIGIT_SEGS [SEG_CODES] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
    8'hBF, 8'h86, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'hA7,
    8'hFF, 8'hEF, 8'hF7, 8'hFC, 8'hB9, 8'hDE, 8'hF9, 8'hF1,
    8'h00, 8'h40
  };

  localparam pins_t LINES_HIGH = '{strobe: 1'b1, clock: 1'b1, data: 1'b1};
  localparam pins_t LINES_OPEN = '{strobe: 1'b0, clock: 1'b1, data: 1'b1};

  // Brightness (the last phase draws a random level instead) and key-line density for each random phase
  localparam logic [3:0] LEVEL_PLAN [PHASES] = '{4'd5, 4'd0, 4'd15, 4'd8, 4'd1, 4'd0};
  localparam int DIO_PLAN [PHASES] = '{50, 0, 3, 100, 1, 10};

  // Results that can be read off directly: strobe, clock, data, busy, key, key_valid
  localparam result_t AT_REST   = '{1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 1'b0};
  localparam result_t ARMED     = '{1'b1, 1'b1, 1'b1, 1'b1, 6'd0, 1'b0};
  localparam result_t STB_LOW   = '{1'b0, 1'b1, 1'b1, 1'b1, 6'd0, 1'b0};
  localparam result_t LINES_LOW = '{1'b0, 1'b0, 1'b0, 1'b1, 6'd0, 1'b0};
  localparam result_t CLK_RISE  = '{1'b0, 1'b1, 1'b0, 1'b1, 6'd0, 1'b0};
  localparam result_t UNTYPED   = '0;

  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } scan_row_t;

  localparam int DIRECTED_ROWS = 24;

  // Directed opening: idle items, extreme digit codes, frame start, ignored start,
  // load during a frame, spare command code, first bits of the mode byte
  localparam scan_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b1}, 1'b1, AT_REST},
    '{'{CMD_SPARE, 3'd7, 6'd63, 1'b0}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd0, 6'd0,  1'b0}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd7, 6'd63, 1'b1}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd1, 6'd33, 1'b0}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd2, 6'd32, 1'b1}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd3, 6'd31, 1'b0}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd4, 6'd16, 1'b1}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd5, 6'd15, 1'b0}, 1'b1, AT_REST},
    '{'{CMD_LOAD,  3'd6, 6'd34, 1'b1}, 1'b1, AT_REST},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b0}, 1'b1, AT_REST},
    '{'{CMD_START, 3'd0, 6'd0,  1'b0}, 1'b1, ARMED},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b1}, 1'b1, STB_LOW},
    '{'{CMD_START, 3'd0, 6'd0,  1'b0}, 1'b1, STB_LOW},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b1}, 1'b1, LINES_LOW},
    '{'{CMD_LOAD,  3'd0, 6'd8,  1'b0}, 1'b1, LINES_LOW},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b0}, 1'b1, CLK_RISE},
    '{'{CMD_SPARE, 3'd0, 6'd0,  1'b1}, 1'b1, CLK_RISE},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b1}, 1'b0, UNTYPED},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b0}, 1'b0, UNTYPED},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b1}, 1'b0, UNTYPED},
    '{'{CMD_LOAD,  3'd7, 6'd9,  1'b1}, 1'b0, UNTYPED},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b0}, 1'b0, UNTYPED},
    '{'{CMD_TICK,  3'd0, 6'd0,  1'b1}, 1'b0, UNTYPED}
  };

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  ledks_item_if   item_ch ();
  ledks_result_if res_ch ();

  led_display_key_scan_serial_master #(
    .NUM_DIGITS    (LED_DIGITS),
    .STB_GAP_TICKS (STB_GAP)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch)
  );

  // Controller model state
  logic [3:0]  m_level;
  logic [5:0]  m_codes [LED_DIGITS];
  logic [7:0]  m_grid [8];
  phase_t      m_phase;
  txn_t        m_txn;
  logic [4:0]  m_bytes;
  logic [3:0]  m_bitph;
  logic [7:0]  m_gap;
  logic [7:0]  m_shift;
  logic [31:0] m_keyword;
  logic [5:0]  m_key;
  pins_t       m_pins;

  result_t pending_results [$];
  int      errors = 0;
  bit      steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("mismatch: %s", what);
    end
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (steady || roll < 70) begin
      return 0;
    end
    if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Advance the controller model by one item and return the pin/key result
  function automatic result_t predict_scan(input item_t it);
    result_t    r;
    logic       kv;
    logic       reading;
    logic       dv;
    logic [7:0] seg;
    logic [7:0] outgoing;
    logic [4:0] txn_len;
    kv = 1'b0;
    case (it.command)
      CMD_LOAD: begin
        m_codes[it.digit_index] = it.digit_code;
      end
      CMD_START: begin
        // Snapshot transposed segments; a start during a frame is dropped
        if (m_phase == PH_IDLE) begin
          for (int g = 0; g < 8; g++) begin
            for (int d = 0; d < LED_DIGITS; d++) begin
              seg = (m_codes[d] < 6'(SEG_CODES)) ? DIGIT_SEGS[m_codes[d]] : BYTE_ZERO;
              m_grid[g][7 - d] = seg[g];
            end
          end
          m_txn = TX_MODE;
          m_phase = PH_OPEN;
        end
      end
      CMD_TICK: begin
        reading = (m_txn == TX_KEYS) && (m_bytes != 5'd0);
        case (m_txn)
          TX_DISPLAY: txn_len = 5'd17;
          TX_KEYS:    txn_len = 5'd5;
          default:    txn_len = 5'd1;
        endcase
        case (m_phase)
          PH_OPEN: begin
            m_pins = LINES_OPEN;
            m_bytes = 5'd0;
            m_bitph = 4'd0;
            if (m_txn == TX_KEYS) begin
              m_keyword = 32'd0;
            end
            m_phase = PH_BITS;
          end
          PH_BITS: begin
            if (!m_bitph[0]) begin
              // Clock low: set up the data line (released while reading)
              if (reading) begin
                dv = 1'b1;
              end else begin
                if (m_bitph == 4'd0) begin
                  case (m_txn)
                    TX_MODE: outgoing = BYTE_MODE;
                    TX_DISPLAY: begin
                      if (m_bytes == 5'd0) begin
                        outgoing = BYTE_ADDR;
                      end else if (m_bytes[0]) begin
                        outgoing = m_grid[3'((m_bytes - 5'd1) >> 1)];
                      end else begin
                        outgoing = BYTE_ZERO;
                      end
                    end
                    TX_KEYS: outgoing = BYTE_KEYS;
                    default: begin
                      if (m_level == 4'd0) begin
                        outgoing = BYTE_DARK;
                      end else if (m_level > LEVEL_TOP) begin
                        outgoing = BYTE_LIT | 8'(LEVEL_TOP - 4'd1);
                      end else begin
                        outgoing = BYTE_LIT | 8'(m_level - 4'd1);
                      end
                    end
                  endcase
                  m_shift = outgoing;
                end
                dv = m_shift[0];
              end
              m_pins = '{strobe: 1'b0, clock: 1'b0, data: dv};
            end else begin
              // Clock high: shift out LSB first, or sample into the LSB
              m_pins.clock = 1'b1;
              if (reading) begin
                m_shift = {m_shift[6:0], it.dio_in};
              end else begin
                m_shift = m_shift >> 1;
              end
            end
            if (m_bitph == 4'd15) begin
              if (reading) begin
                m_keyword[(int'(m_bytes) - 1) * 8 +: 8] = m_shift;
              end
              m_bytes = m_bytes + 5'd1;
              m_bitph = 4'd0;
              if (m_bytes >= txn_len) begin
                m_phase = PH_CLOSE;
              end
            end else begin
              m_bitph = m_bitph + 4'd1;
            end
          end
          PH_CLOSE: begin
            m_pins = LINES_HIGH;
            if (m_txn == TX_KEYS) begin
              m_key = 6'd0;
              for (int i = 0; i < 32; i++) begin
                if (m_keyword[i]) begin
                  m_key = 6'(i + 1);
                end
              end
              kv = 1'b1;
            end
            if (m_txn == TX_BRIGHT) begin
              m_phase = PH_IDLE;
            end else begin
              m_gap = 8'd0;
              m_phase = PH_GAP;
            end
          end
          PH_GAP: begin
            m_pins = LINES_HIGH;
            m_gap = m_gap + 8'd1;
            if (m_gap >= 8'(STB_GAP)) begin
              m_txn = txn_t'(m_txn + 2'd1);
              m_phase = PH_OPEN;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.strobe_pin   = m_pins.strobe;
    r.clock_pin    = m_pins.clock;
    r.data_out_pin = m_pins.data;
    r.busy_res     = (m_phase != PH_IDLE);
    r.key_code     = m_key;
    r.key_valid    = kv;
    return r;
  endfunction

  // Mostly ticks; starts are frequent while idle so frames keep coming
  function automatic item_t random_scan_item(input int dio_pct);
    item_t it;
    int    roll;
    roll = $urandom_range(99);
    it.digit_index = 3'($urandom_range(7));
    it.digit_code  = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(SEG_CODES - 1));
    it.dio_in      = ($urandom_range(99) < dio_pct);
    if (m_phase == PH_IDLE) begin
      if (roll < 30) begin
        it.command = CMD_START;
      end else if (roll < 50) begin
        it.command = CMD_LOAD;
      end else if (roll < 53) begin
        it.command = CMD_SPARE;
      end else begin
        it.command = CMD_TICK;
      end
    end else begin
      if (roll < 2) begin
        it.command = CMD_START;
      end else if (roll < 12) begin
        it.command = CMD_LOAD;
      end else if (roll < 14) begin
        it.command = CMD_SPARE;
      end else begin
        it.command = CMD_TICK;
      end
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send_item(input item_t it, input logic typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.command     <= it.command;
    item_ch.digit_index <= it.digit_index;
    item_ch.digit_code  <= it.digit_code;
    item_ch.dio_in      <= it.dio_in;
    do @(posedge clk); while (!item_ch.ready);
    predicted = predict_scan(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic await_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result side: ready with random stalls
  initial begin : result_sink
    int stall;
    int run;
    res_ch.ready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.strobe_pin, res_ch.clock_pin, res_ch.data_out_pin,
              res_ch.busy_res, res_ch.key_code, res_ch.key_valid};
      if (pending_results.size() == 0) begin
        flag_error("result arrived with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          flag_error($sformatf({"got/expected strobe %b/%b clock %b/%b data %b/%b ",
                                "busy %b/%b key %0d/%0d key_valid %b/%b"},
                               got.strobe_pin, want.strobe_pin, got.clock_pin,
                               want.clock_pin, got.data_out_pin, want.data_out_pin,
                               got.busy_res, want.busy_res, got.key_code, want.key_code,
                               got.key_valid, want.key_valid));
        end
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int         sent;
    int         dio_pct;
    logic [3:0] level;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = 4'd0;
    item_ch.valid       = 1'b0;
    item_ch.command     = CMD_TICK;
    item_ch.digit_index = 3'd0;
    item_ch.digit_code  = 6'd0;
    item_ch.dio_in      = 1'b0;

    // Model state after reset
    m_level   = LEVEL_AT_RESET;
    m_phase   = PH_IDLE;
    m_txn     = TX_MODE;
    m_bytes   = 5'd0;
    m_bitph   = 4'd0;
    m_gap     = 8'd0;
    m_shift   = 8'd0;
    m_keyword = 32'd0;
    m_key     = 6'd0;
    m_pins    = LINES_HIGH;
    for (int d = 0; d < LED_DIGITS; d++) begin
      m_codes[d] = 6'd0;
    end
    for (int g = 0; g < 8; g++) begin
      m_grid[g] = 8'd0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(DIRECTED[r].stim, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random phases; drain every item before each brightness change, so a
    // frame may carry on across a phase boundary with the new level
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        await_results();
        repeat (SETTLE) @(posedge clk);
        level = (p == PHASES - 1) ? 4'($urandom_range(15)) : LEVEL_PLAN[p];
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        m_level = level;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      steady  = (p == 1);
      dio_pct = DIO_PLAN[p];
      sent    = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (p == 2 && sent == ITEMS_PER_PHASE / 2) begin
          await_results();
        end
        send_item(random_scan_item(dio_pct), 1'b0, UNTYPED);
        sent++;
      end
    end

    await_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
